### src/sas_pkg.sv
package sas_pkg;

  localparam int unsigned MAX_PATTERN   = 64;
  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned SYMBOL_W      = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_WB,
    ST_LEAVE_RD,
    ST_LEAVE_WB,
    ST_ENTER_WB
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } bal_ctl_t;

endpackage

### src/sas_req_if.sv
interface sas_req_if;
  logic                          valid;
  logic                          ready;
  logic [sas_pkg::REQ_W-1:0]     req_type;
  logic [sas_pkg::SYMBOL_W-1:0]  symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

### src/sas_rsp_if.sv
interface sas_rsp_if;
  logic valid;
  logic ready;
  logic window_match;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output window_match, output found,
                  output pattern_overflow, input ready);
  modport sink   (input valid, input window_match, input found,
                  input pattern_overflow, output ready);
endinterface

### src/sas_bal_mem.sv
module sas_bal_mem #(
  parameter int unsigned DEPTH  = sas_pkg::ALPHABET_SIZE,
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sas_pkg::bal_ctl_t ctl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

### src/sas_win_mem.sv
module sas_win_mem #(
  parameter int unsigned DEPTH  = sas_pkg::MAX_PATTERN,
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### src/sliding_anagram_search.sv
// Clear, ignored or dropped items and text with an empty pattern give their result in the
// cycle after the transfer; a pattern byte or a text byte before the window fills goes
// through ST_PAT_WB or ST_ENTER_WB first; a text byte with a full window goes through
// ST_LEAVE_RD, ST_LEAVE_WB and ST_ENTER_WB (window read, leaving and entering balance
// updates). New items wait for these states and a free result slot. Reset is asynchronous:
// it clears counters, flags and the balance valid bits at once; window bytes are not reset.
module sliding_anagram_search #(
  parameter int unsigned MAX_PATTERN   = sas_pkg::MAX_PATTERN,
  parameter int unsigned ALPHABET_SIZE = sas_pkg::ALPHABET_SIZE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sas_req_if.sink          req_i,
  sas_rsp_if.source        rsp_o
);

  localparam int unsigned SYM_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned BAL_W = $clog2(MAX_PATTERN + 1) + 1;
  localparam int unsigned NZ_W  = $clog2(ALPHABET_SIZE + 1);
  localparam int unsigned FOLD_MUL = (65536 + ALPHABET_SIZE - 1) / ALPHABET_SIZE;

  sas_pkg::state_e   state_q, state_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [SYM_W-1:0]  leave_q, leave_d;
  logic              full_q, full_d;
  logic              fwd_q, fwd_d;
  logic [BAL_W-1:0]  fwd_val_q, fwd_val_d;
  logic [NZ_W-1:0]   nz_q, nz_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [LEN_W-1:0]  tseen_q, tseen_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic              found_q, found_d;
  logic              ovf_q, ovf_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_match_q, rsp_match_d;
  logic              rsp_found_q, rsp_found_d;
  logic              rsp_ovf_q, rsp_ovf_d;

  sas_pkg::bal_ctl_t bal_ctl;
  logic [SYM_W-1:0]  bal_rd_addr;
  logic [SYM_W-1:0]  bal_wr_addr;
  logic [BAL_W-1:0]  bal_wr_data;
  logic [BAL_W-1:0]  bal_rd_data;
  logic [BAL_W-1:0]  bal_old;
  logic [BAL_W-1:0]  bal_new;

  logic              win_rd_en;
  logic              win_wr_en;
  logic [SYM_W-1:0]  win_rd_data;

  logic              emit;
  logic              match;
  logic [23:0]       fold_prod;
  logic [15:0]       fold_rem;
  logic [SYM_W-1:0]  sym_fold;
  logic [LEN_W-1:0]  wnext;
  logic [LEN_W-1:0]  tseen_inc;

  sas_bal_mem #(
    .DEPTH  (ALPHABET_SIZE),
    .DATA_W (BAL_W),
    .ADDR_W (SYM_W)
  ) u_bal_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (bal_ctl),
    .rd_addr_i (bal_rd_addr),
    .wr_addr_i (bal_wr_addr),
    .wr_data_i (bal_wr_data),
    .rd_data_o (bal_rd_data)
  );

  sas_win_mem #(
    .DEPTH  (MAX_PATTERN),
    .DATA_W (SYM_W),
    .ADDR_W (PTR_W)
  ) u_win_mem (
    .clk_i     (clk_i),
    .wr_en_i   (win_wr_en),
    .wr_addr_i (wptr_q),
    .wr_data_i (sym_q),
    .rd_en_i   (win_rd_en),
    .rd_addr_i (wptr_q),
    .rd_data_o (win_rd_data)
  );

  assign fold_prod   = 24'(req_i.symbol) * 24'(FOLD_MUL);
  assign fold_rem    = 16'(req_i.symbol) - 16'(fold_prod[23:16]) * 16'(ALPHABET_SIZE);
  assign sym_fold    = SYM_W'(fold_rem);
  assign req_i.ready = (state_q == sas_pkg::ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign bal_old     = fwd_q ? fwd_val_q : bal_rd_data;
  assign wnext       = LEN_W'(wptr_q) + LEN_W'(1);
  assign tseen_inc   = tseen_q + LEN_W'(1);

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    leave_d     = leave_q;
    full_d      = full_q;
    fwd_d       = 1'b0;
    fwd_val_d   = fwd_val_q;
    nz_d        = nz_q;
    plen_d      = plen_q;
    tseen_d     = tseen_q;
    wptr_d      = wptr_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    bal_ctl     = '0;
    bal_rd_addr = sym_q;
    bal_wr_addr = sym_q;
    bal_new     = bal_old;
    win_rd_en   = 1'b0;
    win_wr_en   = 1'b0;
    emit        = 1'b0;
    match       = 1'b0;

    case (state_q)
      sas_pkg::ST_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          sym_d  = sym_fold;
          full_d = (tseen_q >= plen_q);
          case (sas_pkg::req_e'(req_i.req_type))
            sas_pkg::REQ_CLEAR: begin
              nz_d        = '0;
              plen_d      = '0;
              tseen_d     = '0;
              wptr_d      = '0;
              found_d     = 1'b0;
              ovf_d       = 1'b0;
              bal_ctl.clr = 1'b1;
              emit        = 1'b1;
            end
            sas_pkg::REQ_PATTERN: begin
              if (tseen_q != '0) begin
                emit = 1'b1;
              end else if (plen_q >= LEN_W'(MAX_PATTERN)) begin
                ovf_d = 1'b1;
                emit  = 1'b1;
              end else begin
                bal_ctl.rd  = 1'b1;
                bal_rd_addr = sym_fold;
                state_d     = sas_pkg::ST_PAT_WB;
              end
            end
            sas_pkg::REQ_TEXT: begin
              if (plen_q == '0) begin
                match   = 1'b1;
                found_d = 1'b1;
                emit    = 1'b1;
              end else if (tseen_q >= plen_q) begin
                win_rd_en = 1'b1;
                state_d   = sas_pkg::ST_LEAVE_RD;
              end else begin
                bal_ctl.rd  = 1'b1;
                bal_rd_addr = sym_fold;
                state_d     = sas_pkg::ST_ENTER_WB;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      sas_pkg::ST_PAT_WB: begin
        bal_new     = bal_old - BAL_W'(1);
        bal_ctl.wr  = 1'b1;
        bal_wr_addr = sym_q;
        plen_d      = plen_q + LEN_W'(1);
        emit        = 1'b1;
        state_d     = sas_pkg::ST_IDLE;
      end
      sas_pkg::ST_LEAVE_RD: begin
        leave_d     = win_rd_data;
        bal_ctl.rd  = 1'b1;
        bal_rd_addr = win_rd_data;
        state_d     = sas_pkg::ST_LEAVE_WB;
      end
      sas_pkg::ST_LEAVE_WB: begin
        bal_new     = bal_old - BAL_W'(1);
        bal_ctl.wr  = 1'b1;
        bal_wr_addr = leave_q;
        bal_ctl.rd  = 1'b1;
        bal_rd_addr = sym_q;
        fwd_d       = (sym_q == leave_q);
        fwd_val_d   = bal_new;
        state_d     = sas_pkg::ST_ENTER_WB;
      end
      sas_pkg::ST_ENTER_WB: begin
        bal_new     = bal_old + BAL_W'(1);
        bal_ctl.wr  = 1'b1;
        bal_wr_addr = sym_q;
        win_wr_en   = 1'b1;
        wptr_d      = (wnext >= plen_q) ? '0 : PTR_W'(wnext);
        if (!full_q) begin
          tseen_d = tseen_inc;
        end
        emit    = 1'b1;
        state_d = sas_pkg::ST_IDLE;
      end
      default: begin
        state_d = sas_pkg::ST_IDLE;
      end
    endcase

    if (bal_ctl.wr) begin
      if (bal_old == '0 && bal_new != '0) begin
        nz_d = nz_q + NZ_W'(1);
      end else if (bal_old != '0 && bal_new == '0) begin
        nz_d = nz_q - NZ_W'(1);
      end
    end

    if (state_q == sas_pkg::ST_ENTER_WB) begin
      match = (full_q || (tseen_inc >= plen_q)) && (nz_d == '0);
      if (match) begin
        found_d = 1'b1;
      end
    end

    bal_wr_data = bal_new;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_match_d = rsp_match_q;
    rsp_found_d = rsp_found_q;
    rsp_ovf_d   = rsp_ovf_q;
    if (emit) begin
      rsp_valid_d = 1'b1;
      rsp_match_d = match;
      rsp_found_d = found_d || (plen_d == '0);
      rsp_ovf_d   = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sas_pkg::ST_IDLE;
      fwd_q       <= 1'b0;
      nz_q        <= '0;
      plen_q      <= '0;
      tseen_q     <= '0;
      wptr_q      <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fwd_q       <= fwd_d;
      nz_q        <= nz_d;
      plen_q      <= plen_d;
      tseen_q     <= tseen_d;
      wptr_q      <= wptr_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    leave_q     <= leave_d;
    full_q      <= full_d;
    fwd_val_q   <= fwd_val_d;
    rsp_match_q <= rsp_match_d;
    rsp_found_q <= rsp_found_d;
    rsp_ovf_q   <= rsp_ovf_d;
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.window_match     = rsp_match_q;
  assign rsp_o.found            = rsp_found_q;
  assign rsp_o.pattern_overflow = rsp_ovf_q;

`ifndef SYNTHESIS
  a_tseen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tseen_q <= plen_q)
    else $error("text count exceeds pattern length");

  a_wptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plen_q == '0) ? (wptr_q == '0) : (LEN_W'(wptr_q) < plen_q))
    else $error("window pointer outside window");

  a_bal_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bal_ctl.wr |-> (state_q != sas_pkg::ST_IDLE) && (state_q != sas_pkg::ST_LEAVE_RD))
    else $error("balance write outside update state");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sas_pkg::ST_PAT_WB || state_q == sas_pkg::ST_ENTER_WB) |-> !rsp_valid_q)
    else $error("result slot busy at update");
`endif

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sas_pkg::REQ_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int               SYMBOL_SPACE = 1 << sas_pkg::SYMBOL_W;
  localparam int               MAX_PAT      = int'(sas_pkg::MAX_PATTERN);
  localparam int               ALPHABET     = int'(sas_pkg::ALPHABET_SIZE);
  localparam int               RANDOM_ITEMS = 850;
  localparam int               CYCLE_LIMIT  = 1_000_000;
  localparam int               HOLD_AFTER   = 300;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               DRAIN_CYCLES = 20;

  typedef logic [sas_pkg::SYMBOL_W-1:0] sym_t;
  typedef logic [sas_pkg::REQ_W-1:0]    kind_t;

  typedef struct packed {
    kind_t kind;
    sym_t  sym;
  } req_item_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic pattern_overflow;
  } verdict_t;

  logic clk;
  logic rst_n;

  sas_req_if req_if ();
  sas_rsp_if rsp_if ();

  sliding_anagram_search uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_item_t pending[$];
  verdict_t  verdicts[$];

  int   cyc         = 0;
  int   accepted    = 0;
  int   errors      = 0;
  int   total_items = 0;
  logic req_taken   = 1'b0;
  int   tx_gap      = 0;
  int   rx_stall    = 0;
  int   hold_cnt    = 0;
  bit   hold_done   = 1'b0;
  bit   tx_idle_en  = 1'b1;
  bit   rx_idle_en  = 1'b1;

  // Search state mirrored from the block.
  int                  balance[SYMBOL_SPACE];
  int                  nonzero;
  sym_t                win_bytes[MAX_PAT];
  int                  win_ptr;
  int                  pat_len;
  int                  text_cnt;
  bit                  found_hit;
  bit                  overflow_hit;

  function automatic void clear_search();
    foreach (balance[i]) balance[i] = 0;
    nonzero      = 0;
    win_ptr      = 0;
    pat_len      = 0;
    text_cnt     = 0;
    found_hit    = 1'b0;
    overflow_hit = 1'b0;
  endfunction

  function automatic void shift_balance(int s, int delta);
    int old_bal;
    old_bal = balance[s];
    balance[s] = old_bal + delta;
    if (old_bal == 0 && balance[s] != 0) nonzero++;
    else if (old_bal != 0 && balance[s] == 0) nonzero--;
  endfunction

  function automatic verdict_t anagram_step(kind_t k, sym_t s);
    verdict_t v;
    int       sym;
    int       slot;
    v   = '0;
    sym = int'(s) % ALPHABET;
    if (k == sas_pkg::REQ_CLEAR) begin
      clear_search();
    end else if (k == sas_pkg::REQ_PATTERN) begin
      if (text_cnt == 0) begin
        if (pat_len >= MAX_PAT) begin
          overflow_hit = 1'b1;
        end else begin
          shift_balance(sym, -1);
          pat_len++;
        end
      end
    end else if (k == sas_pkg::REQ_TEXT) begin
      if (pat_len == 0) begin
        v.window_match = 1'b1;
      end else begin
        slot = (win_ptr < MAX_PAT) ? win_ptr : 0;
        if (text_cnt >= pat_len) shift_balance(int'(win_bytes[slot]), -1);
        else text_cnt++;
        shift_balance(sym, 1);
        win_bytes[slot] = sym_t'(sym);
        slot++;
        win_ptr = (slot >= pat_len) ? 0 : slot;
        v.window_match = (text_cnt >= pat_len) && (nonzero == 0);
      end
      if (v.window_match) found_hit = 1'b1;
    end
    v.found            = found_hit || (pat_len == 0);
    v.pattern_overflow = overflow_hit;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sym_t draw_symbol(int base, int span);
    return sym_t'((base + $urandom_range(0, span - 1)) % SYMBOL_SPACE);
  endfunction

  function automatic sym_t rand_symbol();
    return sym_t'($urandom);
  endfunction

  task automatic queue_item(kind_t k, sym_t s);
    pending.push_back('{kind: k, sym: s});
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = sas_pkg::REQ_CLEAR;
    req_if.symbol   = '0;
    rsp_if.ready    = 1'b0;
  end

  // driver
  always @(negedge clk) begin
    req_item_t nxt;
    if (cyc % 200 == 0) tx_idle_en = ($urandom_range(0, 3) != 0);
    if (rst_n && (!req_if.valid || req_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        req_if.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        nxt = pending.pop_front();
        req_if.req_type <= nxt.kind;
        req_if.symbol   <= nxt.sym;
        req_if.valid    <= 1'b1;
        if (tx_idle_en) tx_gap = pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (cyc % 160 == 0) rx_idle_en = ($urandom_range(0, 3) != 0);
    if (!hold_done && accepted >= HOLD_AFTER) begin
      hold_cnt  = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if (rx_idle_en) rx_stall = pick_gap();
    end
  end

  // monitor: check each result transfer, then predict each request transfer
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    req_taken <= rst_n && req_if.valid && req_if.ready;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.window_match     = rsp_if.window_match;
      got.found            = rsp_if.found;
      got.pattern_overflow = rsp_if.pattern_overflow;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing outstanding: match=%b found=%b ovf=%b",
                   $realtime, got.window_match, got.found, got.pattern_overflow);
      end else begin
        want = verdicts.pop_front();
        if (got.window_match !== want.window_match || got.found !== want.found ||
            got.pattern_overflow !== want.pattern_overflow) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch match exp %b got %b, found exp %b got %b, ovf exp %b got %b",
                     $realtime, want.window_match, got.window_match, want.found, got.found,
                     want.pattern_overflow, got.pattern_overflow);
        end
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      verdicts.push_back(anagram_step(req_if.req_type, req_if.symbol));
      accepted++;
    end
  end

  initial begin
    sym_t pat[MAX_PAT];
    sym_t perm[MAX_PAT];
    sym_t tmp;
    int counted;
    int r;
    int want_len;
    int kept;
    int tlen;
    int n;
    int j;
    int base;
    int span;

    rst_n = 1'b0;
    clear_search();

    // empty pattern, code 3, extremes, late pattern byte, window fill and slide
    queue_item(sas_pkg::REQ_TEXT, 8'h00);
    queue_item(sas_pkg::REQ_TEXT, 8'hFF);
    queue_item(REQ_UNUSED, 8'hAA);
    queue_item(sas_pkg::REQ_CLEAR, 8'h00);
    queue_item(sas_pkg::REQ_PATTERN, 8'h00);
    queue_item(sas_pkg::REQ_PATTERN, 8'hFF);
    queue_item(sas_pkg::REQ_PATTERN, 8'h55);
    queue_item(sas_pkg::REQ_TEXT, 8'hFF);
    queue_item(sas_pkg::REQ_PATTERN, 8'h01);
    queue_item(sas_pkg::REQ_TEXT, 8'h00);
    queue_item(sas_pkg::REQ_TEXT, 8'h55);
    queue_item(sas_pkg::REQ_TEXT, 8'hAA);
    queue_item(REQ_UNUSED, 8'h55);
    queue_item(sas_pkg::REQ_TEXT, 8'hFF);
    queue_item(sas_pkg::REQ_TEXT, 8'h00);
    queue_item(sas_pkg::REQ_TEXT, 8'h55);
    queue_item(sas_pkg::REQ_CLEAR, 8'hFF);
    queue_item(sas_pkg::REQ_PATTERN, 8'h80);
    queue_item(sas_pkg::REQ_TEXT, 8'h80);
    queue_item(sas_pkg::REQ_TEXT, 8'h7F);
    queue_item(sas_pkg::REQ_TEXT, 8'h80);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      queue_item(sas_pkg::REQ_CLEAR, rand_symbol());
      counted++;
      r = $urandom_range(0, 99);
      if (r < 8) want_len = 0;
      else if (r < 85) want_len = $urandom_range(1, 8);
      else if (r < 95) want_len = $urandom_range(9, 40);
      else want_len = $urandom_range(MAX_PAT - 4, MAX_PAT + 6);
      base = $urandom_range(0, SYMBOL_SPACE - 1);
      span = ($urandom_range(0, 4) == 0) ? SYMBOL_SPACE : $urandom_range(1, 4);
      for (int i = 0; i < want_len; i++) begin
        tmp = draw_symbol(base, span);
        if (i < MAX_PAT) pat[i] = tmp;
        queue_item(sas_pkg::REQ_PATTERN, tmp);
        counted++;
      end
      kept = (want_len < MAX_PAT) ? want_len : MAX_PAT;
      tlen = want_len + $urandom_range(0, (want_len > 20) ? 40 : 3 * want_len + 8);
      n = 0;
      while (n < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          queue_item(sas_pkg::REQ_PATTERN, rand_symbol());
        end else if (r < 7) begin
          queue_item(REQ_UNUSED, rand_symbol());
        end else if (r < 9) begin
          queue_item(sas_pkg::REQ_CLEAR, rand_symbol());
          kept = 0;
          n++;
          counted++;
        end else if (r < 30 && kept > 0) begin
          for (int i = 0; i < kept; i++) perm[i] = pat[i];
          for (int i = kept - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int i = 0; i < kept; i++) queue_item(sas_pkg::REQ_TEXT, perm[i]);
          n       += kept;
          counted += kept;
        end else begin
          queue_item(sas_pkg::REQ_TEXT, draw_symbol(base, span));
          n++;
          counted++;
        end
      end
    end
    total_items = pending.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted < total_items) @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
src/sas_pkg.sv
src/sas_req_if.sv
src/sas_rsp_if.sv
src/sas_bal_mem.sv
src/sas_win_mem.sv
src/sliding_anagram_search.sv
verif/testbench.sv
